>>> sv/assert_macros.svh
// Assertion macros shared by the escape-time fractal pixel RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ETF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked across reset.
`define ETF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/etf_pkg.sv
// Shared types, widths, constants and helper functions for the
// escape-time fractal pixel unit. No dependencies.
package etf_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 28;
    localparam int COUNT_BITS = 16;

    // Fixed-point word and configuration data width.
    localparam int Z_W   = 32;
    localparam int CFG_W = 32;
    localparam int IDX_W = 3;

    // Intermediate widths of the iteration and point arithmetic.
    localparam int PRD_W  = 2 * Z_W;
    localparam int SQ_W   = PRD_W - FRAC_BITS + 1;
    localparam int XR_W   = PRD_W - FRAC_BITS + 2;
    localparam int LIM_W  = FRAC_BITS + 4;
    localparam int ESC_W  = (SQ_W + 1 > LIM_W) ? SQ_W + 1 : LIM_W;
    localparam int PPR_W  = COORD_BITS + 1 + Z_W;
    localparam int PT_W   = PPR_W + 1;
    localparam int SAT_W  = (PT_W > XR_W + 1) ? PT_W : XR_W + 1;

    // Escape radius squared, 4.0 in fixed point.
    localparam logic signed [ESC_W-1:0] LIMIT4 = ESC_W'(1) << (FRAC_BITS + 2);

    localparam logic signed [Z_W-1:0] ZMAX = {1'b0, {(Z_W-1){1'b1}}};
    localparam logic signed [Z_W-1:0] ZMIN = {1'b1, {(Z_W-1){1'b0}}};
    localparam logic signed [SAT_W-1:0] ZMAX_EXT = SAT_W'(ZMAX);
    localparam logic signed [SAT_W-1:0] ZMIN_EXT = SAT_W'(ZMIN);

    // Register reset values: -2.5 and -1.0 for the origin, 256 iterations.
    localparam logic [COUNT_BITS-1:0] MAX_ITER_RST  = COUNT_BITS'(256);
    localparam logic signed [Z_W-1:0] ORIGIN_RE_RST =
        Z_W'(-(64'sd5 <<< (FRAC_BITS - 1)));
    localparam logic signed [Z_W-1:0] ORIGIN_IM_RST =
        Z_W'(-(64'sd1 <<< FRAC_BITS));

    typedef enum logic [IDX_W-1:0] {
        REG_MODE      = 3'd0,
        REG_MAX_ITER  = 3'd1,
        REG_ORIGIN_RE = 3'd2,
        REG_ORIGIN_IM = 3'd3,
        REG_STEP_RE   = 3'd4,
        REG_STEP_IM   = 3'd5,
        REG_SEED_RE   = 3'd6,
        REG_SEED_IM   = 3'd7
    } t_reg_idx;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic load_prod;
        logic load_point;
        logic mul;
        logic step;
        logic capture;
        logic in_set;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic zero_limit;
        logic escape;
        logic last;
    } t_status;

    // Clamp a wide signed value to the fixed-point word range.
    function automatic logic signed [Z_W-1:0] sat_z(input logic signed [SAT_W-1:0] v);
        logic signed [Z_W-1:0] res;
        if (v > ZMAX_EXT) begin
            res = ZMAX;
        end else if (v < ZMIN_EXT) begin
            res = ZMIN;
        end else begin
            res = $signed(v[Z_W-1:0]);
        end
        return res;
    endfunction

endpackage

>>> sv/etf_datapath.sv
// Datapath of the escape-time fractal pixel unit: configuration registers,
// point mapping, the z*z + c iteration and the result register. Uses etf_pkg.
module etf_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [etf_pkg::IDX_W-1:0]       i_cfg_index,
    input  logic [etf_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic [etf_pkg::COORD_BITS-1:0]  i_column,
    input  logic [etf_pkg::COORD_BITS-1:0]  i_row,
    input  etf_pkg::t_cmd                   i_cmd,
    output etf_pkg::t_status                o_status,
    output logic [etf_pkg::COUNT_BITS-1:0]  o_iteration_count,
    output logic                            o_inside_set
);

    logic                                 r_mode;
    logic [etf_pkg::COUNT_BITS-1:0]       r_max_iter;
    logic signed [etf_pkg::Z_W-1:0]       r_origin_re, r_origin_im;
    logic signed [etf_pkg::Z_W-1:0]       r_step_re, r_step_im;
    logic signed [etf_pkg::Z_W-1:0]       r_seed_re, r_seed_im;

    logic [etf_pkg::COORD_BITS-1:0]       r_column, r_row;
    logic signed [etf_pkg::PPR_W-1:0]     r_prod_re, r_prod_im;
    logic signed [etf_pkg::Z_W-1:0]       r_zr, r_zi, r_cr, r_ci;
    logic signed [etf_pkg::PRD_W-1:0]     r_sq_re, r_sq_im, r_cross;
    logic [etf_pkg::COUNT_BITS-1:0]       r_count;
    logic [etf_pkg::COUNT_BITS-1:0]       r_out_count;
    logic                                 r_out_inside;

    logic signed [etf_pkg::Z_W-1:0]       w_pt_re, w_pt_im;
    logic signed [etf_pkg::SQ_W-1:0]      w_rr, w_ii;
    logic signed [etf_pkg::XR_W-1:0]      w_xr;
    logic signed [etf_pkg::ESC_W-1:0]     w_mag;
    logic signed [etf_pkg::Z_W-1:0]       w_nr, w_ni;
    logic [etf_pkg::COUNT_BITS-1:0]       w_count_inc;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_max_iter  <= etf_pkg::MAX_ITER_RST;
            r_origin_re <= etf_pkg::ORIGIN_RE_RST;
            r_origin_im <= etf_pkg::ORIGIN_IM_RST;
            r_step_re   <= '0;
            r_step_im   <= '0;
            r_seed_re   <= '0;
            r_seed_im   <= '0;
        end else if (i_cfg_we) begin
            case (etf_pkg::t_reg_idx'(i_cfg_index))
                etf_pkg::REG_MODE:      r_mode      <= i_cfg_data[0];
                etf_pkg::REG_MAX_ITER:  r_max_iter  <= i_cfg_data[etf_pkg::COUNT_BITS-1:0];
                etf_pkg::REG_ORIGIN_RE: r_origin_re <= $signed(i_cfg_data[etf_pkg::Z_W-1:0]);
                etf_pkg::REG_ORIGIN_IM: r_origin_im <= $signed(i_cfg_data[etf_pkg::Z_W-1:0]);
                etf_pkg::REG_STEP_RE:   r_step_re   <= $signed(i_cfg_data[etf_pkg::Z_W-1:0]);
                etf_pkg::REG_STEP_IM:   r_step_im   <= $signed(i_cfg_data[etf_pkg::Z_W-1:0]);
                etf_pkg::REG_SEED_RE:   r_seed_re   <= $signed(i_cfg_data[etf_pkg::Z_W-1:0]);
                etf_pkg::REG_SEED_IM:   r_seed_im   <= $signed(i_cfg_data[etf_pkg::Z_W-1:0]);
                default: ;
            endcase
        end
    end

    // Point mapping: origin plus the registered index-times-step product.
    assign w_pt_re = etf_pkg::sat_z(etf_pkg::SAT_W'(r_origin_re) + etf_pkg::SAT_W'(r_prod_re));
    assign w_pt_im = etf_pkg::sat_z(etf_pkg::SAT_W'(r_origin_im) + etf_pkg::SAT_W'(r_prod_im));

    // Arithmetic shifts floor the truncated products.
    assign w_rr  = etf_pkg::SQ_W'(r_sq_re >>> etf_pkg::FRAC_BITS);
    assign w_ii  = etf_pkg::SQ_W'(r_sq_im >>> etf_pkg::FRAC_BITS);
    assign w_xr  = etf_pkg::XR_W'(r_cross >>> (etf_pkg::FRAC_BITS - 1));
    assign w_mag = etf_pkg::ESC_W'(w_rr) + etf_pkg::ESC_W'(w_ii);

    assign w_nr = etf_pkg::sat_z(etf_pkg::SAT_W'(w_rr) - etf_pkg::SAT_W'(w_ii)
                                 + etf_pkg::SAT_W'(r_cr));
    assign w_ni = etf_pkg::sat_z(etf_pkg::SAT_W'(w_xr) + etf_pkg::SAT_W'(r_ci));

    assign w_count_inc = r_count + 1'b1;

    assign o_status.zero_limit = (r_max_iter == '0);
    assign o_status.escape     = (w_mag > etf_pkg::LIMIT4);
    assign o_status.last       = (w_count_inc == r_max_iter);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_column <= i_column;
            r_row    <= i_row;
        end
        if (i_cmd.load_prod) begin
            r_prod_re <= $signed({1'b0, r_column}) * r_step_re;
            r_prod_im <= $signed({1'b0, r_row}) * r_step_im;
        end
        if (i_cmd.load_point) begin
            r_count <= '0;
            if (r_mode) begin
                r_zr <= w_pt_re;
                r_zi <= w_pt_im;
                r_cr <= r_seed_re;
                r_ci <= r_seed_im;
            end else begin
                r_zr <= '0;
                r_zi <= '0;
                r_cr <= w_pt_re;
                r_ci <= w_pt_im;
            end
        end
        if (i_cmd.mul) begin
            r_sq_re <= r_zr * r_zr;
            r_sq_im <= r_zi * r_zi;
            r_cross <= r_zr * r_zi;
        end
        if (i_cmd.step) begin
            r_zr    <= w_nr;
            r_zi    <= w_ni;
            r_count <= w_count_inc;
        end
        if (i_cmd.capture) begin
            r_out_count  <= r_count;
            r_out_inside <= i_cmd.in_set;
        end
    end

    assign o_iteration_count = r_out_count;
    assign o_inside_set      = r_out_inside;

endmodule

>>> sv/etf_ctrl.sv
// Controller of the escape-time fractal pixel unit: sequences point mapping,
// the multiply and update steps, and the output handshake. Uses etf_pkg.
`include "assert_macros.svh"

module etf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  etf_pkg::t_status i_status,
    output etf_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROD,
        S_POINT,
        S_MUL,
        S_UPD,
        S_HOLD
    } t_state;

    t_state        r_state, n_state;
    logic          r_out_valid, n_out_valid;
    logic          r_inside, n_inside;
    etf_pkg::t_cmd w_cmd;
    logic          w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        n_inside    = r_inside;
        w_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                w_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_PROD;
                end
            end
            S_PROD: begin
                w_cmd.load_prod = 1'b1;
                n_state = S_POINT;
            end
            S_POINT: begin
                w_cmd.load_point = 1'b1;
                // A zero limit finishes at once with no test made.
                if (i_status.zero_limit) begin
                    n_inside = 1'b1;
                    n_state  = S_HOLD;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                w_cmd.mul = 1'b1;
                n_state = S_UPD;
            end
            S_UPD: begin
                if (i_status.escape) begin
                    n_inside = 1'b0;
                    n_state  = S_HOLD;
                end else begin
                    w_cmd.step = 1'b1;
                    if (i_status.last) begin
                        n_inside = 1'b1;
                        n_state  = S_HOLD;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_HOLD: begin
                // Wait until the previous result has been transferred.
                if (w_out_free) begin
                    w_cmd.capture = 1'b1;
                    w_cmd.in_set  = r_inside;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_inside    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_inside    <= n_inside;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

    `ETF_ASSERT(a_busy_after_accept, i_clk, i_rst_n,
        (i_in_valid && o_in_ready) |=> !o_in_ready, "input taken while a pixel is in work")
    `ETF_ASSERT(a_capture_when_free, i_clk, i_rst_n,
        w_cmd.capture |-> (!r_out_valid || i_out_ready), "result overwritten before transfer")
    `ETF_ASSERT(a_step_not_on_escape, i_clk, i_rst_n,
        w_cmd.step |-> (r_state == S_UPD && !i_status.escape), "z updated after escape")
    `ETF_ASSERT_ALWAYS(a_reset_state, i_clk,
        !i_rst_n |=> (!o_out_valid && o_in_ready), "block not idle after reset")

endmodule

>>> sv/escape_time_fractal_pixel_unit.sv
// Escape-time fractal pixel unit (Mandelbrot / Julia), top level.
// Instantiates etf_ctrl and etf_datapath; uses etf_pkg.
//
// Usage: configure mode, iteration limit, origin, step and seed through the
// write port (i_cfg_we, i_cfg_index, i_cfg_data) while the block is idle.
// Each transfer on the input channel (i_in_valid, o_in_ready, i_column,
// i_row) yields one transfer on the output channel (o_out_valid,
// i_out_ready, o_iteration_count, o_inside_set).
// Pixels are processed one at a time: the index-times-step products are
// registered and then the point is formed; each iteration then registers
// the three 32x32 products and afterwards makes the escape test and z update.
// The output register holds its result until it is taken, and a new pixel
// may be accepted meanwhile; a finished pixel waits only if the previous
// result is still untaken.
// Reset restores the register defaults (Mandelbrot, 256 iterations, origin
// -2.5 - 1.0i, zero step and seed), empties the output and leaves the
// block ready for input.
module escape_time_fractal_pixel_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [etf_pkg::IDX_W-1:0]       i_cfg_index,
    input  logic [etf_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [etf_pkg::COORD_BITS-1:0]  i_column,
    input  logic [etf_pkg::COORD_BITS-1:0]  i_row,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [etf_pkg::COUNT_BITS-1:0]  o_iteration_count,
    output logic                            o_inside_set
);

    etf_pkg::t_cmd    w_cmd;
    etf_pkg::t_status w_status;

    etf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    etf_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_column          (i_column),
        .i_row             (i_row),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .o_iteration_count (o_iteration_count),
        .o_inside_set      (o_inside_set)
    );

endmodule
